// ----- hw/rtl/fcsg_pkg.sv -----
// ----------------------------------------------------------------------------
// fcsg_pkg
// Shared types and constants of the filled circle span generator.
// ----------------------------------------------------------------------------
package fcsg_pkg;

  localparam int MAX_RADIUS_DEF = 64;
  localparam int MAX_RESULTS    = 64;

  localparam int CENTER_W = 15;
  localparam int RADIUS_W = 7;
  localparam int COORD_W  = 16;
  localparam int STEP_W   = 8;
  localparam int DELTA_W  = 8;
  localparam int ERR_W    = 16;
  localparam int COUNT_W  = $clog2(MAX_RESULTS + 1);

  // Request queue between front and back; the depth is a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [CENTER_W-1:0] center_x;
    logic signed [CENTER_W-1:0] center_y;
    logic        [RADIUS_W-1:0] radius;
  } req_t;

endpackage

// ----- hw/rtl/fcsg_front.sv -----
// ----------------------------------------------------------------------------
// fcsg_front
// Accepts circle requests, clamps the radius, drops empty circles and holds
// the rest in a short queue for the span iterator.
// ----------------------------------------------------------------------------
module fcsg_front #(
  parameter int MAX_RADIUS = fcsg_pkg::MAX_RADIUS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [fcsg_pkg::CENTER_W-1:0] in_center_x,
  input  logic signed [fcsg_pkg::CENTER_W-1:0] in_center_y,
  input  logic        [fcsg_pkg::RADIUS_W-1:0] in_radius_px,
  output logic                                 q_valid,
  output fcsg_pkg::req_t                       q_req,
  input  logic                                 q_pop
);

  fcsg_pkg::req_t                    mem_r [fcsg_pkg::QUEUE_DEPTH];
  logic [fcsg_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [fcsg_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [fcsg_pkg::QCNT_W-1:0]       count_r;
  logic [fcsg_pkg::RADIUS_W-1:0]     radius_sat;
  logic                              push;
  logic                              pop;
  fcsg_pkg::req_t                    req_in;

  always_comb begin
    if (in_radius_px > fcsg_pkg::RADIUS_W'(MAX_RADIUS)) begin
      radius_sat = fcsg_pkg::RADIUS_W'(MAX_RADIUS);
    end else begin
      radius_sat = in_radius_px;
    end
    req_in.center_x = in_center_x;
    req_in.center_y = in_center_y;
    req_in.radius   = radius_sat;
  end

  assign in_stall = (count_r == fcsg_pkg::QCNT_W'(fcsg_pkg::QUEUE_DEPTH));
  // A zero radius is taken and dropped here: it produces no spans.
  assign push     = in_valid && !in_stall && (radius_sat != '0);
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_req    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= fcsg_pkg::QCNT_W'(fcsg_pkg::QUEUE_DEPTH))
    else $error("request queue over capacity");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> !q_valid)
    else $error("queue presents a request while empty");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue count did not drop on a pop");

endmodule

// ----- hw/rtl/fcsg_back.sv -----
// ----------------------------------------------------------------------------
// fcsg_back
// Midpoint circle iterator: one step per cycle while the output is not
// stalled, each step written as one span beat into the output register.
// ----------------------------------------------------------------------------
module fcsg_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  fcsg_pkg::req_t                      q_req,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fcsg_pkg::COORD_W-1:0] out_wide_left,
  output logic signed [fcsg_pkg::COORD_W-1:0] out_wide_right,
  output logic signed [fcsg_pkg::COORD_W-1:0] out_wide_row_low,
  output logic signed [fcsg_pkg::COORD_W-1:0] out_wide_row_high,
  output logic signed [fcsg_pkg::COORD_W-1:0] out_narrow_left,
  output logic signed [fcsg_pkg::COORD_W-1:0] out_narrow_right,
  output logic signed [fcsg_pkg::COORD_W-1:0] out_narrow_row_low,
  output logic signed [fcsg_pkg::COORD_W-1:0] out_narrow_row_high,
  output logic                                out_last_step
);

  localparam int CW = fcsg_pkg::COORD_W;
  localparam int EW = fcsg_pkg::ERR_W;

  logic                                busy_r;
  logic [fcsg_pkg::STEP_W-1:0]         x_r, y_r;
  logic [fcsg_pkg::DELTA_W-1:0]        dx_r, dy_r, diam_r;
  logic signed [EW-1:0]                err_r;
  logic [fcsg_pkg::COUNT_W-1:0]        cnt_r;
  logic signed [fcsg_pkg::CENTER_W-1:0] cx_r, cy_r;

  logic                                out_valid_r, last_r;
  logic signed [CW-1:0]                wl_r, wr_r, wrl_r, wrh_r, nl_r, nr_r, nrl_r, nrh_r;

  logic                                adv;
  logic [fcsg_pkg::STEP_W-1:0]         x_nxt, y_nxt;
  logic [fcsg_pkg::DELTA_W-1:0]        dx_nxt, dy_nxt;
  logic signed [EW-1:0]                err_mid, err_nxt;
  logic [fcsg_pkg::COUNT_W-1:0]        cnt_nxt;
  logic                                more;
  logic signed [CW-1:0]                cx_e, cy_e, x_e, y_e;

  assign q_pop = q_valid && !busy_r;
  assign adv   = busy_r && (!out_valid_r || !out_stall);

  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    dx_nxt  = dx_r;
    dy_nxt  = dy_r;
    err_mid = err_r;
    if (err_r <= 0) begin
      y_nxt   = y_r + 1'b1;
      err_mid = err_r + $signed({{(EW-fcsg_pkg::DELTA_W){1'b0}}, dy_r});
      dy_nxt  = dy_r + 8'd2;
    end
    err_nxt = err_mid;
    if (err_mid > 0) begin
      x_nxt   = x_r - 1'b1;
      dx_nxt  = dx_r + 8'd2;
      err_nxt = err_mid + $signed({{(EW-fcsg_pkg::DELTA_W){1'b0}}, dx_nxt})
                        - $signed({{(EW-fcsg_pkg::DELTA_W){1'b0}}, diam_r});
    end
    cnt_nxt = cnt_r + 1'b1;
    more    = (x_nxt >= y_nxt) && (cnt_nxt < fcsg_pkg::COUNT_W'(fcsg_pkg::MAX_RESULTS));
  end

  assign cx_e = CW'(cx_r);
  assign cy_e = CW'(cy_r);
  assign x_e  = $signed({{(CW-fcsg_pkg::STEP_W){1'b0}}, x_r});
  assign y_e  = $signed({{(CW-fcsg_pkg::STEP_W){1'b0}}, y_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
      end else if (adv) begin
        busy_r <= more;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cx_r   <= q_req.center_x;
      cy_r   <= q_req.center_y;
      x_r    <= fcsg_pkg::STEP_W'(q_req.radius) - 1'b1;
      y_r    <= '0;
      dx_r   <= fcsg_pkg::DELTA_W'(1);
      dy_r   <= fcsg_pkg::DELTA_W'(1);
      diam_r <= {q_req.radius, 1'b0};
      err_r  <= EW'(1) - $signed({{(EW-fcsg_pkg::RADIUS_W-1){1'b0}}, q_req.radius, 1'b0});
      cnt_r  <= '0;
    end else if (adv) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      err_r <= err_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wl_r   <= cx_e - x_e;
      wr_r   <= cx_e + x_e;
      wrl_r  <= cy_e + y_e;
      wrh_r  <= cy_e - y_e;
      nl_r   <= cx_e - y_e;
      nr_r   <= cx_e + y_e;
      nrl_r  <= cy_e + x_e;
      nrh_r  <= cy_e - x_e;
      last_r <= !more;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_wide_left       = wl_r;
  assign out_wide_right      = wr_r;
  assign out_wide_row_low    = wrl_r;
  assign out_wide_row_high   = wrh_r;
  assign out_narrow_left     = nl_r;
  assign out_narrow_right    = nr_r;
  assign out_narrow_row_low  = nrl_r;
  assign out_narrow_row_high = nrh_r;
  assign out_last_step       = last_r;

  a_x_ge_y: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (x_r >= y_r))
    else $error("iterator running with x below y");

  a_odd_deltas: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (dx_r[0] && dy_r[0]))
    else $error("step increments lost their odd parity");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r < fcsg_pkg::COUNT_W'(fcsg_pkg::MAX_RESULTS)))
    else $error("iterator ran past the result cap");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !more) |=> !busy_r)
    else $error("iterator still busy after the final step");

endmodule

// ----- hw/rtl/filled_circle_span_generator.sv -----
// The first span beat of a request is registered after the request queue and
// the loaded iterator state. One span beat per cycle while a circle runs and
// the output is not stalled; the single-step midpoint iterator in the back end
// loads the next circle only after the last step of the current one.
// A zero-radius request is absorbed by the front end and yields no beats.
// Reset (synchronous, rst_n low) empties the request queue and idles the back.
// ----------------------------------------------------------------------------
// filled_circle_span_generator
// Midpoint circle generator producing four horizontal fill spans per step.
// ----------------------------------------------------------------------------
module filled_circle_span_generator #(
  parameter int MAX_RADIUS = fcsg_pkg::MAX_RADIUS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [fcsg_pkg::CENTER_W-1:0] in_center_x,
  input  logic signed [fcsg_pkg::CENTER_W-1:0] in_center_y,
  input  logic        [fcsg_pkg::RADIUS_W-1:0] in_radius_px,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [fcsg_pkg::COORD_W-1:0]  out_wide_left,
  output logic signed [fcsg_pkg::COORD_W-1:0]  out_wide_right,
  output logic signed [fcsg_pkg::COORD_W-1:0]  out_wide_row_low,
  output logic signed [fcsg_pkg::COORD_W-1:0]  out_wide_row_high,
  output logic signed [fcsg_pkg::COORD_W-1:0]  out_narrow_left,
  output logic signed [fcsg_pkg::COORD_W-1:0]  out_narrow_right,
  output logic signed [fcsg_pkg::COORD_W-1:0]  out_narrow_row_low,
  output logic signed [fcsg_pkg::COORD_W-1:0]  out_narrow_row_high,
  output logic                                 out_last_step
);

  logic           q_valid;
  logic           q_pop;
  fcsg_pkg::req_t q_req;

  fcsg_front #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_center_x  (in_center_x),
    .in_center_y  (in_center_y),
    .in_radius_px (in_radius_px),
    .q_valid      (q_valid),
    .q_req        (q_req),
    .q_pop        (q_pop)
  );

  fcsg_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_req               (q_req),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_wide_left       (out_wide_left),
    .out_wide_right      (out_wide_right),
    .out_wide_row_low    (out_wide_row_low),
    .out_wide_row_high   (out_wide_row_high),
    .out_narrow_left     (out_narrow_left),
    .out_narrow_right    (out_narrow_right),
    .out_narrow_row_low  (out_narrow_row_low),
    .out_narrow_row_high (out_narrow_row_high),
    .out_last_step       (out_last_step)
  );

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Filled circle span generator testbench
// Sends circle requests, with directed corner cases first and then random
// ones, and compares every span beat with a midpoint-circle predictor
// that the scoreboard keeps. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_CIRCLES = 163;

  typedef struct {
    logic signed [fcsg_pkg::COORD_W-1:0] wide_left;
    logic signed [fcsg_pkg::COORD_W-1:0] wide_right;
    logic signed [fcsg_pkg::COORD_W-1:0] wide_row_low;
    logic signed [fcsg_pkg::COORD_W-1:0] wide_row_high;
    logic signed [fcsg_pkg::COORD_W-1:0] narrow_left;
    logic signed [fcsg_pkg::COORD_W-1:0] narrow_right;
    logic signed [fcsg_pkg::COORD_W-1:0] narrow_row_low;
    logic signed [fcsg_pkg::COORD_W-1:0] narrow_row_high;
    logic                                last_step;
  } span_set_t;

  class span_scoreboard;
    span_set_t expected_spans[$];
    int failures = 0;

    function int pending();
      return expected_spans.size();
    endfunction

    function void queue_span(span_set_t s);
      expected_spans.insert(expected_spans.size(), s);
    endfunction

    // Runs the whole midpoint iteration for one accepted circle request.
    function void note_request(logic signed [fcsg_pkg::CENTER_W-1:0] cx_in,
                               logic signed [fcsg_pkg::CENTER_W-1:0] cy_in,
                               logic [fcsg_pkg::RADIUS_W-1:0] radius_in);
      int cx;
      int cy;
      int rad;
      int diam;
      int x;
      int y;
      int dx;
      int dy;
      int err;
      int count;
      span_set_t held;
      span_set_t fresh;
      bit have_held;
      cx = cx_in;
      cy = cy_in;
      rad = radius_in;
      if (rad > fcsg_pkg::MAX_RADIUS_DEF) rad = fcsg_pkg::MAX_RADIUS_DEF;
      diam = 2 * rad;
      x = rad - 1;
      y = 0;
      dx = 1;
      dy = 1;
      err = dx - diam;
      count = 0;
      have_held = 1'b0;
      while (x >= y && count < fcsg_pkg::MAX_RESULTS) begin
        fresh.wide_left       = fcsg_pkg::COORD_W'(cx - x);
        fresh.wide_right      = fcsg_pkg::COORD_W'(cx + x);
        fresh.wide_row_low    = fcsg_pkg::COORD_W'(cy + y);
        fresh.wide_row_high   = fcsg_pkg::COORD_W'(cy - y);
        fresh.narrow_left     = fcsg_pkg::COORD_W'(cx - y);
        fresh.narrow_right    = fcsg_pkg::COORD_W'(cx + y);
        fresh.narrow_row_low  = fcsg_pkg::COORD_W'(cy + x);
        fresh.narrow_row_high = fcsg_pkg::COORD_W'(cy - x);
        fresh.last_step       = 1'b0;
        // Hold one beat back so the final one can be flagged before it is queued.
        if (have_held) queue_span(held);
        held = fresh;
        have_held = 1'b1;
        count++;
        if (err <= 0) begin
          y++;
          err += dy;
          dy += 2;
        end
        if (err > 0) begin
          x--;
          dx += 2;
          err += dx - diam;
        end
      end
      if (have_held) begin
        held.last_step = 1'b1;
        queue_span(held);
      end
    endfunction

    function void match_field(string name, int want, int got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_span(span_set_t got);
      span_set_t want;
      if (expected_spans.size() == 0) begin
        $error("span beat arrived with no circle outstanding");
        failures++;
        return;
      end
      want = expected_spans.pop_front();
      match_field("wide_left", want.wide_left, got.wide_left);
      match_field("wide_right", want.wide_right, got.wide_right);
      match_field("wide_row_low", want.wide_row_low, got.wide_row_low);
      match_field("wide_row_high", want.wide_row_high, got.wide_row_high);
      match_field("narrow_left", want.narrow_left, got.narrow_left);
      match_field("narrow_right", want.narrow_right, got.narrow_right);
      match_field("narrow_row_low", want.narrow_row_low, got.narrow_row_low);
      match_field("narrow_row_high", want.narrow_row_high, got.narrow_row_high);
      match_field("last_step", want.last_step, got.last_step);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [fcsg_pkg::CENTER_W-1:0] in_center_x = '0;
  logic signed [fcsg_pkg::CENTER_W-1:0] in_center_y = '0;
  logic [fcsg_pkg::RADIUS_W-1:0] in_radius_px = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [fcsg_pkg::COORD_W-1:0] out_wide_left;
  logic signed [fcsg_pkg::COORD_W-1:0] out_wide_right;
  logic signed [fcsg_pkg::COORD_W-1:0] out_wide_row_low;
  logic signed [fcsg_pkg::COORD_W-1:0] out_wide_row_high;
  logic signed [fcsg_pkg::COORD_W-1:0] out_narrow_left;
  logic signed [fcsg_pkg::COORD_W-1:0] out_narrow_right;
  logic signed [fcsg_pkg::COORD_W-1:0] out_narrow_row_low;
  logic signed [fcsg_pkg::COORD_W-1:0] out_narrow_row_high;
  logic out_last_step;

  span_scoreboard circle_sb = new();
  span_set_t seen_beat;
  int idle_cycles = 0;
  int stall_left = 0;
  int free_left = 0;
  bit quiet = 1'b0;

  filled_circle_span_generator dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_center_x         (in_center_x),
    .in_center_y         (in_center_y),
    .in_radius_px        (in_radius_px),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_wide_left       (out_wide_left),
    .out_wide_right      (out_wide_right),
    .out_wide_row_low    (out_wide_row_low),
    .out_wide_row_high   (out_wide_row_high),
    .out_narrow_left     (out_narrow_left),
    .out_narrow_right    (out_narrow_right),
    .out_narrow_row_low  (out_narrow_row_low),
    .out_narrow_row_high (out_narrow_row_high),
    .out_last_step       (out_last_step)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one, and none during quiet phases.
  function automatic int pick_gap();
    int p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (free_left > 0 || quiet) begin
      out_stall <= 1'b0;
      if (free_left > 0) free_left <= free_left - 1;
    end else begin
      out_stall <= 1'b0;
      free_left <= $urandom_range(0, 12);
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        circle_sb.note_request(in_center_x, in_center_y, in_radius_px);
      end
      if (out_valid && !out_stall) begin
        seen_beat.wide_left       = out_wide_left;
        seen_beat.wide_right      = out_wide_right;
        seen_beat.wide_row_low    = out_wide_row_low;
        seen_beat.wide_row_high   = out_wide_row_high;
        seen_beat.narrow_left     = out_narrow_left;
        seen_beat.narrow_right    = out_narrow_right;
        seen_beat.narrow_row_low  = out_narrow_row_low;
        seen_beat.narrow_row_high = out_narrow_row_high;
        seen_beat.last_step       = out_last_step;
        circle_sb.check_span(seen_beat);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // Called just after a rising edge; returns at the edge that accepts the beat.
  task automatic send_circle(input int cx, input int cy, input int radius);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_center_x <= cx[fcsg_pkg::CENTER_W-1:0];
    in_center_y <= cy[fcsg_pkg::CENTER_W-1:0];
    in_radius_px <= radius[fcsg_pkg::RADIUS_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random_circle();
    int p;
    int cx;
    int cy;
    int radius;
    p = $urandom_range(0, 99);
    if (p < 10) radius = 0;
    else if (p < 70) radius = $urandom_range(1, 16);
    else if (p < 90) radius = $urandom_range(17, fcsg_pkg::MAX_RADIUS_DEF);
    else radius = $urandom_range(fcsg_pkg::MAX_RADIUS_DEF + 1, 127);
    cx = $urandom_range(0, 32767);
    cy = $urandom_range(0, 32767);
    // Centers near the edges of the coordinate range now and then.
    if ($urandom_range(0, 4) == 0) cx = $urandom_range(0, 1) ? 16383 : -16384;
    if ($urandom_range(0, 4) == 0) cy = $urandom_range(0, 1) ? 16383 : -16384;
    send_circle(cx, cy, radius);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_circle(0, 0, 0);
    send_circle(0, 0, 1);
    send_circle(0, 0, 2);
    send_circle(0, 0, 3);
    send_circle(0, 0, 0);
    send_circle(0, 0, 0);
    send_circle(-1, -1, 1);
    send_circle(100, -100, 64);
    send_circle(-16384, -16384, 64);
    send_circle(16383, 16383, 64);
    send_circle(16383, -16384, 65);
    send_circle(-16384, 16383, 127);
    send_circle(5, 5, 100);
    send_circle(16383, 0, 10);
    send_circle(-16384, 0, 33);
    send_circle(0, 16383, 63);
    send_circle(-7, 9, 4);

    for (int i = 0; i < RANDOM_CIRCLES; i++) begin
      quiet = ((i / 30) % 3 == 2);
      send_random_circle();
    end
    quiet = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (circle_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (circle_sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
